// ===== rtl/trial_division_prime_test_top_defines.svh =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_top_defines.svh
// assertion macros for the trial division prime test block
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// checked only while reset is low
`define TDPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TDPT_ASSERT(lbl, clk, rst, prop, msg)
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared constants for the trial division prime test block
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

endpackage

// ===== rtl/trial_division_prime_test_top.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// reports whether the magnitude of a signed integer is prime, by trial
// division with odd divisors and one shared restoring subtract/compare unit
//
//   channel  signals                        direction
//   request  in_valid, in_stall, value      in  (in_stall driven here)
//   result   out_valid, out_stall, is_prime out (out_stall driven outside)
//
// zero, one and even magnitudes: result valid the cycle after the request
// odd magnitude m: one trial division per odd divisor d with d*d <= m, until
//   one divides m; one remainder bit per cycle in the shared subtract unit
// in_stall is high from acceptance until the result is taken
// rst is synchronous, active high; it returns the sequencer to idle
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_top_defines.svh"

module trial_division_prime_test_top
  import tdpt_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_prime
);

  localparam int unsigned IDX_W = $clog2(DATA_WIDTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_WIDTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                state;
  logic [DATA_WIDTH-1:0] mag;
  logic [DATA_WIDTH-1:0] d;
  logic [DATA_WIDTH+1:0] sq;
  logic [DATA_WIDTH:0]   rem;
  logic [IDX_W-1:0]      bit_idx;

  logic [DATA_WIDTH-1:0] value_mag;
  logic [DATA_WIDTH:0]   rem_shift;
  logic [DATA_WIDTH:0]   d_ext;
  logic                  rem_ge;
  logic [DATA_WIDTH:0]   rem_next;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

  // two's complement magnitude; the most negative value maps to 2^(W-1)
  assign value_mag = value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;

  // one restoring division step
  assign rem_shift = {rem[DATA_WIDTH-1:0], mag[bit_idx]};
  assign d_ext     = {1'b0, d};
  assign rem_ge    = (rem_shift >= d_ext);
  assign rem_next  = rem_ge ? (rem_shift - d_ext) : rem_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mag <= value_mag;
            d   <= DATA_WIDTH'(3);
            sq  <= (DATA_WIDTH + 2)'(9);
            if (value_mag[DATA_WIDTH-1:1] == '0) begin
              is_prime <= 1'b0;
              state    <= ST_DONE;
            end else if (!value_mag[0]) begin
              is_prime <= (value_mag == DATA_WIDTH'(2));
              state    <= ST_DONE;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          // walk ends once the divisor squared passes the magnitude
          if (sq > {2'b00, mag}) begin
            is_prime <= 1'b1;
            state    <= ST_DONE;
          end else begin
            rem     <= '0;
            bit_idx <= IDX_LAST;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem     <= rem_next;
          bit_idx <= bit_idx - IDX_W'(1);
          if (bit_idx == '0) begin
            if (rem_next == '0) begin
              is_prime <= 1'b0;
              state    <= ST_DONE;
            end else begin
              // (d+2)^2 = d^2 + 4d + 4
              d     <= d + DATA_WIDTH'(2);
              sq    <= sq + {d, 2'b00} + (DATA_WIDTH + 2)'(4);
              state <= ST_CHECK;
            end
          end
        end
        ST_DONE: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TDPT_ASSERT(a_even_fast, clk, rst, (in_valid && !in_stall && !value[0]) |=> out_valid, "even or zero request did not finish in one cycle")

  `TDPT_ASSERT(a_div_odd, clk, rst, (state == ST_DIV) |-> d[0], "trial divisor is even")

  `TDPT_ASSERT(a_rem_below_d, clk, rst, (state == ST_DIV) |-> (rem < d_ext), "partial remainder not below divisor")

  `TDPT_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (!in_stall && !out_valid), "block not idle after reset")

endmodule
